FILE: hw/rtl/ates_pkg.sv
// shared types, constants and microcode table for the ternary extremum search
package ates_pkg;

   localparam int VAL_W = 32;
   localparam int IDX_W = 10;
   localparam int SPAN_MIN = 3;
   // x / 3 == (x * 0xaaab) >> 17, exact for x below 2**16
   localparam logic [16:0] RECIP3 = 17'h0aaab;
   localparam int RECIP3_SHIFT = 17;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] extreme_index;
      logic             empty_res;
      logic             overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_TEST,
      ST_MREAD,
      ST_MCMP,
      ST_TREAD,
      ST_TCMP1,
      ST_TCMP2,
      ST_EMIT
   } step_type;

   typedef enum logic [2:0] {
      SEQ_NEXT,
      SEQ_GOTO,
      SEQ_WAIT_LAST,
      SEQ_IF_SMALL,
      SEQ_WAIT_EMIT
   } seq_type;

   typedef struct packed {
      logic     ld_diff;
      logic     ld_third;
      logic     rd_mid;
      logic     upd_mid;
      logic     rd_tail;
      logic     cmp1;
      logic     cmp2;
      logic     emit;
      seq_type  seq;
      step_type target;
   } ctrl_type;

   localparam ctrl_type CTRL_NOP = '{
      ld_diff: 1'b0, ld_third: 1'b0, rd_mid: 1'b0, upd_mid: 1'b0, rd_tail: 1'b0,
      cmp1: 1'b0, cmp2: 1'b0, emit: 1'b0, seq: SEQ_NEXT, target: ST_IDLE
   };

   // microcode rom: one control word per step
   function automatic ctrl_type ucode(step_type s);
      ctrl_type c;
      c = CTRL_NOP;
      unique case (s)
         ST_IDLE: begin
            c.seq = SEQ_WAIT_LAST;
         end
         ST_DIFF: begin
            c.ld_diff = 1'b1;
         end
         ST_TEST: begin
            c.ld_third = 1'b1;
            c.seq      = SEQ_IF_SMALL;
            c.target   = ST_TREAD;
         end
         ST_MREAD: begin
            c.rd_mid = 1'b1;
         end
         ST_MCMP: begin
            c.upd_mid = 1'b1;
            c.seq     = SEQ_GOTO;
            c.target  = ST_DIFF;
         end
         ST_TREAD: begin
            c.rd_tail = 1'b1;
         end
         ST_TCMP1: begin
            c.cmp1 = 1'b1;
         end
         ST_TCMP2: begin
            c.cmp2 = 1'b1;
         end
         ST_EMIT: begin
            c.emit   = 1'b1;
            c.seq    = SEQ_WAIT_EMIT;
            c.target = ST_IDLE;
         end
         default: begin
            c.seq    = SEQ_GOTO;
            c.target = ST_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/array_ternary_extremum_search.sv
// ternary search for the peak or valley of a streamed unimodal array
//
//  port group  dir  handshake        transaction
//  req_*       in   valid / ready    one element, last marks end of set
//  rsp_*       out  valid / ready    index of extremum, empty and overflow flags
//  csr_*       in   write enable     find_valley select
//
// loading writes each accepted element through the single store write port while idle
// on the last element the sequencer runs each search step (diff, test, mid read, mid
// compare) through the two-port store read, then a final scan, and returns to loading
// the result waits in an output register while the next set loads; the next search
// runs, but its emit step holds until that result is taken
// reset is synchronous: clears count, drop, rsp_valid, sequencer, csr; not the store
module array_ternary_extremum_search
   import ates_pkg::*;
#(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = AW + RECIP3_SHIFT;
   localparam int EW = (AW > IDX_W) ? AW : IDX_W;

   logic signed [DATA_WIDTH-1:0] store_mem [DEPTH];

   step_type step_ff, step_in;
   ctrl_type ctrl;

   logic            valley_ff, valley_in;
   logic [AW:0]     count_ff, count_in;
   logic            drop_ff, drop_in;
   logic            ovf_ff, ovf_in;
   logic            empty_ff, empty_in;
   logic [AW-1:0]   lo_ff, lo_in;
   logic [AW-1:0]   hi_ff, hi_in;
   logic [AW:0]     diff_ff, diff_in;
   logic [AW-1:0]   third_ff, third_in;
   logic [AW-1:0]   m1_ff, m1_in;
   logic [AW-1:0]   m2_ff, m2_in;
   logic [AW-1:0]   best_ff, best_in;
   logic signed [DATA_WIDTH-1:0] best_val_ff, best_val_in;
   logic signed [DATA_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            accept, start, full, span_small;
   logic [AW:0]     n_set;
   logic [AW-1:0]   addr_a, addr_b, m1_c, m2_c;
   logic [PW-1:0]   prod;
   logic [EW-1:0]   best_ext;
   logic            a_beats_b, b_beats_a, b_beats_a_t, a_beats_best;

   function automatic logic better(logic signed [DATA_WIDTH-1:0] x,
                                   logic signed [DATA_WIDTH-1:0] y, logic valley);
      return valley ? (x < y) : (x > y);
   endfunction

   assign ctrl      = ucode(step_ff);
   assign req_ready = (step_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign start     = accept && req_data.last;
   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign n_set     = full ? count_ff : count_ff + 1'b1;

   // span is negative or below three: go to the final scan
   assign span_small = diff_ff[AW] || (diff_ff < (AW+1)'(SPAN_MIN));
   assign prod  = PW'(diff_ff[AW-1:0]) * PW'(RECIP3);
   assign m1_c  = lo_ff + third_ff;
   assign m2_c  = hi_ff - third_ff;

   // read port selection
   always_comb begin
      addr_a = lo_ff;
      addr_b = lo_ff + 1'b1;
      if (ctrl.rd_mid) begin
         addr_a = m1_c;
         addr_b = m2_c;
      end else if (ctrl.cmp1) begin
         addr_a = lo_ff + AW'(2);
      end
   end

   assign b_beats_a    = better(rd_b_ff, rd_a_ff, valley_ff);
   assign a_beats_b    = better(rd_a_ff, rd_b_ff, valley_ff);
   assign b_beats_a_t  = !diff_ff[AW] && (diff_ff != '0) && b_beats_a;
   assign a_beats_best = !diff_ff[AW] && (diff_ff[AW:1] != '0)
                         && better(rd_a_ff, best_val_ff, valley_ff);

   // next step
   always_comb begin
      step_in = step_ff;
      unique case (ctrl.seq)
         SEQ_NEXT:      step_in = step_type'(step_ff + 1'b1);
         SEQ_GOTO:      step_in = ctrl.target;
         SEQ_WAIT_LAST: if (start) step_in = step_type'(step_ff + 1'b1);
         SEQ_IF_SMALL:  step_in = span_small ? ctrl.target : step_type'(step_ff + 1'b1);
         SEQ_WAIT_EMIT: if (!rsp_valid_ff) step_in = ctrl.target;
         default:       step_in = ST_IDLE;
      endcase
   end

   // datapath driven by the control word
   always_comb begin
      valley_in    = csr_wr_en ? csr_wr_data : valley_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      ovf_in       = ovf_ff;
      empty_in     = empty_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      diff_in      = diff_ff;
      third_in     = third_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      best_in      = best_ff;
      best_val_in  = best_val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         if (full) drop_in = 1'b1;
         else      count_in = count_ff + 1'b1;
      end
      if (start) begin
         count_in = '0;
         drop_in  = 1'b0;
         ovf_in   = drop_ff || full;
         empty_in = (n_set == '0);
         lo_in    = '0;
         hi_in    = (n_set == '0) ? '0 : AW'(n_set - 1'b1);
      end

      if (ctrl.ld_diff)  diff_in  = {1'b0, hi_ff} - {1'b0, lo_ff};
      if (ctrl.ld_third) third_in = prod[PW-1:RECIP3_SHIFT];
      if (ctrl.rd_mid) begin
         m1_in = m1_c;
         m2_in = m2_c;
      end
      if (ctrl.upd_mid) begin
         if (b_beats_a) begin
            lo_in = m1_ff + 1'b1;
         end else if (a_beats_b) begin
            hi_in = m2_ff - 1'b1;
         end else begin
            lo_in = m1_ff + 1'b1;
            hi_in = m2_ff - 1'b1;
         end
      end
      if (ctrl.rd_tail) best_in = lo_ff;
      if (ctrl.cmp1) begin
         if (b_beats_a_t) begin
            best_in     = lo_ff + 1'b1;
            best_val_in = rd_b_ff;
         end else begin
            best_val_in = rd_a_ff;
         end
      end
      if (ctrl.cmp2 && a_beats_best) best_in = lo_ff + AW'(2);

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (ctrl.emit && !rsp_valid_ff) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.extreme_index = best_ext[IDX_W-1:0];
         rsp_data_in.empty_res     = empty_ff;
         rsp_data_in.overflow      = ovf_ff;
      end
   end

   assign best_ext = EW'(best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         valley_ff    <= 1'b0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         valley_ff    <= valley_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff      <= ovf_in;
      empty_ff    <= empty_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      diff_ff     <= diff_in;
      third_ff    <= third_in;
      m1_ff       <= m1_in;
      m2_ff       <= m2_in;
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   // element store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (accept && !full) store_mem[count_ff[AW-1:0]] <= DATA_WIDTH'(req_data.value);
      rd_a_ff <= store_mem[addr_a];
      rd_b_ff <= store_mem[addr_b];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff == ST_EMIT))
      else $error("result raised outside the emit step");

   a_probe_order: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_MCMP) |-> (m1_ff < m2_ff))
      else $error("one-third probes out of order");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH))
      else $error("element count beyond store depth");

   a_set_restart: assert property (@(posedge clock) disable iff (reset)
      (step_ff != ST_IDLE) |-> (count_ff == '0 && !drop_ff))
      else $error("set not cleared during search");

endmodule

FILE: sim/tb_array_ternary_extremum_search.sv
// testbench for array_ternary_extremum_search: streamed sets against a search predictor
module tb_array_ternary_extremum_search;
   import ates_pkg::*;

   localparam int DEPTH = 1024;
   localparam int SPLIT = 3;
   localparam int SETTLE_CYCLES = 120;   // longer than a full search over DEPTH entries
   localparam int ITEM_TARGET = 1600;
   localparam longint VMAX = 2147483647;
   localparam longint VMIN = -VMAX - 1;
   localparam logic signed [VAL_W-1:0] S_MAX = 32'sh7fffffff;
   localparam logic signed [VAL_W-1:0] S_MIN = 32'sh80000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic    csr_wr_data;

   array_ternary_extremum_search #(
      .DEPTH(DEPTH),
      .DATA_WIDTH(VAL_W)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // shadow copy of the element store and search mode
   logic signed [VAL_W-1:0] elem_mem [DEPTH];
   int      elem_count;
   bit      elem_dropped;
   bit      valley_mode;
   rsp_type extremum_q[$];

   int fail_count;
   int elements_sent;
   int sets_sent;
   int valley_sets;
   int overflow_sets;
   int results_seen;
   int rsp_hold;
   bit quiet;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      bit                      last;
      bit                      valley;
      bit                      typed;
      logic [IDX_W-1:0]        idx;
   } dir_row_type;

   dir_row_type dir_rows[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic bit beats(int a, int b);
      return valley_mode ? (elem_mem[a] < elem_mem[b]) : (elem_mem[a] > elem_mem[b]);
   endfunction

   function automatic int locate_extremum(int n);
      int lo, hi, d, m1, m2, best;
      lo = 0;
      hi = n - 1;
      while (hi - lo >= SPLIT) begin
         d  = hi - lo;
         m1 = lo + d / SPLIT;
         m2 = hi - d / SPLIT;
         if (beats(m2, m1)) begin
            lo = m1 + 1;
         end else if (beats(m1, m2)) begin
            hi = m2 - 1;
         end else begin
            lo = m1 + 1;
            hi = m2 - 1;
         end
      end
      best = lo;
      if (lo + 1 <= hi && beats(lo + 1, best)) best = lo + 1;
      if (lo + 2 <= hi && beats(lo + 2, best)) best = lo + 2;
      return best;
   endfunction

   task automatic absorb_element(input logic signed [VAL_W-1:0] v, input bit last,
                                 output rsp_type r);
      r = '0;
      if (elem_count < DEPTH) begin
         elem_mem[elem_count] = v;
         elem_count++;
      end else begin
         elem_dropped = 1'b1;
      end
      if (last) begin
         if (elem_count == 0) r.empty_res = 1'b1;
         else r.extreme_index = IDX_W'(locate_extremum(elem_count));
         r.overflow   = elem_dropped;
         elem_count   = 0;
         elem_dropped = 1'b0;
      end
   endtask

   function automatic int draw_wait();
      if (quiet || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 15);
   endfunction

   // called just after a falling edge, returns just after a falling edge
   task automatic send_element(input logic signed [VAL_W-1:0] v, input bit last,
                               input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type r;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data.value <= v;
      req_data.last  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_element(v, last, r);
      elements_sent++;
      if (last) begin
         extremum_q.push_back(typed ? typed_rsp : r);
         sets_sent++;
         if (valley_mode) valley_sets++;
         if (r.overflow) overflow_sets++;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (extremum_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_mode(input bit m);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      valley_mode = m;
   endtask

   // slope +1 builds a peak, -1 a valley, 0 gives unshaped noise
   task automatic send_set(input int n, input int slope, input int flat_pct);
      longint v, step;
      int     pk;
      pk = $urandom_range(0, n - 1);
      v  = longint'($signed($urandom));
      for (int i = 0; i < n; i++) begin
         if (slope == 0) begin
            v = longint'($signed($urandom));
         end else if (i > 0) begin
            if ($urandom_range(0, 99) < flat_pct) step = 0;
            else if ($urandom_range(0, 1) == 0) step = $urandom_range(1, 100);
            else step = $urandom_range(1, 1 << 28);
            v = v + ((i <= pk) ? slope : -slope) * step;
            if (v > VMAX) v = VMAX;
            if (v < VMIN) v = VMIN;
         end
         send_element(VAL_W'(v), i == n - 1, 1'b0, '0);
      end
   endtask

   // fills the store with a strict ramp, then pushes two more that get dropped
   task automatic send_full_ramp();
      longint base, step, v;
      step = $urandom_range(1, 4000000);
      base = valley_mode ? VMAX - $urandom_range(0, 1000) : VMIN + $urandom_range(0, 1000);
      for (int i = 0; i < DEPTH + 2; i++) begin
         if (i < DEPTH) v = valley_mode ? base - i * step : base + i * step;
         else v = longint'($signed($urandom));
         send_element(VAL_W'(v), i == DEPTH + 1, 1'b0, '0);
      end
   endtask

   task automatic tab(input logic signed [VAL_W-1:0] v, input bit last, input bit valley,
                      input bit typed, input logic [IDX_W-1:0] idx);
      dir_rows.push_back('{value: v, last: last, valley: valley, typed: typed, idx: idx});
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_result
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_hold = draw_wait();
         if (extremum_q.size() == 0) begin
            $error("result with nothing pending: extreme_index %0d", rsp_data.extreme_index);
            fail_count++;
         end else begin
            want = extremum_q.pop_front();
            results_seen++;
            if (rsp_data.extreme_index !== want.extreme_index) begin
               $error("extreme_index expected %0d actual %0d",
                      want.extreme_index, rsp_data.extreme_index);
               fail_count++;
            end
            if (rsp_data.empty_res !== want.empty_res) begin
               $error("empty_res expected %0d actual %0d", want.empty_res, rsp_data.empty_res);
               fail_count++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow expected %0d actual %0d", want.overflow, rsp_data.overflow);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int      cur_mode;
      int      phase;
      int      phase_start;
      int      n;
      int      pick;
      int      target;
      rsp_type typed_rsp;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      elem_count  = 0;
      elem_dropped = 1'b0;
      valley_mode = 1'b0;
      fail_count  = 0;
      rsp_hold    = 0;
      quiet       = 1'b0;

      //    value          last valley typed idx
      tab(S_MAX,            1,  0,     1,    0);   // lone maximum value
      tab(S_MIN,            1,  0,     1,    0);   // lone minimum value
      tab(S_MIN,            0,  0,     0,    0);
      tab(S_MAX,            1,  0,     1,    1);   // two entries, peak second
      tab(5,                0,  0,     0,    0);   // tie in the final scan
      tab(9,                0,  0,     0,    0);
      tab(9,                1,  0,     0,    0);
      tab(1,                0,  0,     0,    0);
      tab(7,                0,  0,     0,    0);
      tab(3,                0,  0,     0,    0);
      tab(-2,               1,  0,     0,    0);
      tab(4,                0,  0,     0,    0);   // flat set, both ends shrink
      tab(4,                0,  0,     0,    0);
      tab(4,                0,  0,     0,    0);
      tab(4,                1,  0,     0,    0);
      tab(10,               0,  0,     0,    0);   // not unimodal
      tab(-20,              0,  0,     0,    0);
      tab(30,               0,  0,     0,    0);
      tab(-40,              0,  0,     0,    0);
      tab(50,               0,  0,     0,    0);
      tab(-60,              1,  0,     0,    0);
      tab(3,                0,  1,     0,    0);   // valley search
      tab(-1,               0,  1,     0,    0);
      tab(-5,               0,  1,     0,    0);
      tab(2,                1,  1,     0,    0);
      tab(S_MIN,            1,  1,     1,    0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      cur_mode = -1;
      foreach (dir_rows[i]) begin
         if (int'(dir_rows[i].valley) != cur_mode) begin
            set_mode(dir_rows[i].valley);
            cur_mode = dir_rows[i].valley;
         end
         typed_rsp = '{extreme_index: dir_rows[i].idx, empty_res: 1'b0, overflow: 1'b0};
         send_element(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, typed_rsp);
      end

      // total element count for the whole run, the full ramp included
      target = ITEM_TARGET;
      for (phase = 0; elements_sent < target; phase++) begin
         set_mode((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
         quiet = (phase % 4 == 3);
         phase_start = elements_sent;
         if (phase == 2) send_full_ramp();
         while (elements_sent - phase_start < 200 && elements_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) n = $urandom_range(1, 16);
            else if (pick < 97) n = $urandom_range(17, 100);
            else n = $urandom_range(101, 400);
            pick = $urandom_range(0, 99);
            // mostly well-shaped sets for the current mode, the rest flat, noise or inverted
            if (pick < 75) send_set(n, valley_mode ? -1 : 1, 5);
            else if (pick < 85) send_set(n, valley_mode ? -1 : 1, 60);
            else if (pick < 95) send_set(n, 0, 0);
            else send_set(n, valley_mode ? 1 : -1, 10);
         end
      end

      wait_drained();
      quiet = 1'b1;
      $display("%0d elements in %0d sets (%0d valley, %0d with dropped elements), %0d results",
               elements_sent, sets_sent, valley_sets, overflow_sets, results_seen);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/ates_pkg.sv
hw/rtl/array_ternary_extremum_search.sv
sim/tb_array_ternary_extremum_search.sv
